FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// A property that must hold at every rising edge outside reset.
`define LNSF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// A condition that must never be true outside reset.
`define LNSF_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define LNSF_ASSERT(label, prop, msg)
`define LNSF_ASSERT_NEVER(label, cond, msg)
`endif
`endif

FILE: design/lnsf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LIF neuron package
// Types, register codes and saturating helpers shared by the neuron block.
// ----------------------------------------------------------------------------
package lnsf_pkg;

  // Number of synaptic current fields that are summed per kind.
  localparam int unsigned FIELDS_PER_KIND = 2;
  localparam int unsigned EXC_INPUTS      = 2;
  localparam int unsigned INH_INPUTS      = 2;

  typedef enum logic [2:0] {
    REG_REST_VOLTAGE   = 3'd0,
    REG_RESET_VOLTAGE  = 3'd1,
    REG_OFFSET_CURRENT = 3'd2,
    REG_MEMBRANE_RES   = 3'd3,
    REG_DECAY_FACTOR   = 3'd4,
    REG_REFRACT_STEPS  = 3'd5,
    REG_SLOPE_GAIN     = 3'd6,
    REG_SLOPE_GAIN_CMP = 3'd7
  } reg_idx_e;

  typedef enum logic {
    OP_UPDATE = 1'b0,
    OP_SPIKED = 1'b1
  } op_e;

  typedef struct packed {
    logic signed [31:0] rest_voltage;
    logic signed [31:0] reset_voltage;
    logic signed [31:0] offset_current;
    logic signed [31:0] membrane_resistance;
    logic signed [31:0] decay_factor;
    logic        [15:0] refractory_steps;
    logic signed [31:0] slope_gain;
    logic signed [31:0] slope_gain_complement;
  } cfg_t;

  // One entry of the neuron table.
  typedef struct packed {
    logic signed [31:0] voltage;
    logic signed [31:0] prev_voltage;
    logic signed [31:0] slope;
    logic signed [31:0] filtered;
    logic        [15:0] refractory;
  } neuron_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_ALPHA,
    ST_DIFF,
    ST_DECAY,
    ST_VOLT,
    ST_SLOPE,
    ST_FMUL,
    ST_FILT,
    ST_FINISH
  } state_e;

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    return sat33(s);
  endfunction

  function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} - {b[31], b};
    return sat33(s);
  endfunction

endpackage

FILE: design/lnsf_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LIF neuron configuration registers
// Holds the shared neuron parameters, written through a plain write port.
// ----------------------------------------------------------------------------
module lnsf_cfg_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                we_i,
  input  logic [2:0]          index_i,
  input  logic [31:0]         data_i,
  output lnsf_pkg::cfg_t      cfg_o
);

  lnsf_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (we_i) begin
      unique case (lnsf_pkg::reg_idx_e'(index_i))
        lnsf_pkg::REG_REST_VOLTAGE:   cfg_q.rest_voltage          <= data_i;
        lnsf_pkg::REG_RESET_VOLTAGE:  cfg_q.reset_voltage         <= data_i;
        lnsf_pkg::REG_OFFSET_CURRENT: cfg_q.offset_current        <= data_i;
        lnsf_pkg::REG_MEMBRANE_RES:   cfg_q.membrane_resistance   <= data_i;
        lnsf_pkg::REG_DECAY_FACTOR:   cfg_q.decay_factor          <= data_i;
        lnsf_pkg::REG_REFRACT_STEPS:  cfg_q.refractory_steps      <= data_i[15:0];
        lnsf_pkg::REG_SLOPE_GAIN:     cfg_q.slope_gain            <= data_i;
        lnsf_pkg::REG_SLOPE_GAIN_CMP: cfg_q.slope_gain_complement <= data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: design/lnsf_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LIF neuron fixed-point multiplier
// Registered s16.15 product: full product, floor shift by 15, saturate to 32.
// ----------------------------------------------------------------------------
module lnsf_mul (
  input  logic               clk_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic signed [31:0] product_o
);

  logic signed [63:0] full;
  logic signed [48:0] shifted;
  logic signed [31:0] product_d;
  logic signed [31:0] product_q;

  always_comb begin
    full = 64'(a_i) * 64'(b_i);
    // Dropping the low bits of a two's complement value rounds toward minus infinity.
    shifted = full[63:15];
    if (shifted[48:31] == {18{shifted[31]}}) begin
      product_d = shifted[31:0];
    end else begin
      product_d = shifted[48] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
  end

  always_ff @(posedge clk_i) begin
    product_q <= product_d;
  end

  assign product_o = product_q;

endmodule

FILE: design/lnsf_state_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LIF neuron state memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lnsf_state_ram #(
  parameter int unsigned Depth     = 256,
  parameter int unsigned AddrWidth = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [AddrWidth-1:0]    waddr_i,
  input  lnsf_pkg::neuron_t       wdata_i,
  input  logic                    re_i,
  input  logic [AddrWidth-1:0]    raddr_i,
  output lnsf_pkg::neuron_t       rdata_o
);

  lnsf_pkg::neuron_t mem_q [Depth];
  lnsf_pkg::neuron_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/lif_neuron_with_slope_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LIF neuron table with slope filter
// Steps a table of leaky integrate-and-fire neurons in s16.15 fixed point.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake              | Payload
//  ---------+-----------+------------------------+-------------------------------
//  command  | in        | start, busy            | operation, neuron_index, currents
//  result   | out       | done_o (one-cycle)     | membrane_voltage, slopes
//  config   | in        | cfg_we_i               | cfg_index_i, cfg_data_i
//
//  A command beat is taken at a rising edge with start high and busy low.
//  From that edge a normal update runs through every step of the sequence, a
//  refractory update skips the voltage steps, and a spike or an out-of-table
//  index goes straight to the write-back; the next command can be taken in the
//  cycle that shows the result. The sequence is set by the four products through
//  the one shared multiplier and the read-modify-write of the state memory.
//  After reset the block clears the state memory, one entry a cycle, with busy
//  high until every entry is cleared; configuration writes are taken meanwhile.
//  The result beat cannot be stalled: done_o is high for exactly one cycle.
//
module lif_neuron_with_slope_filter #(
  parameter int unsigned NEURONS = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Command channel
  input  logic               start,
  output logic               busy,
  input  logic               operation_i,
  input  logic [7:0]         neuron_index_i,
  input  logic signed [31:0] exc_current_0_i,
  input  logic signed [31:0] exc_current_1_i,
  input  logic signed [31:0] inh_current_0_i,
  input  logic signed [31:0] inh_current_1_i,
  input  logic signed [31:0] bias_current_i,
  // Result channel
  output logic               done_o,
  output logic signed [31:0] membrane_voltage_o,
  output logic signed [31:0] voltage_slope_o,
  output logic signed [31:0] filtered_slope_o,
  // Configuration port
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

`include "assert_macros.svh"

  localparam int unsigned AW = (NEURONS > 1) ? $clog2(NEURONS) : 1;

  lnsf_pkg::cfg_t    cfg;
  lnsf_pkg::neuron_t rd;
  lnsf_pkg::neuron_t wdata;
  lnsf_pkg::state_e  state_q, state_d;

  logic               accept;
  logic [15:0]        idx_wide;
  logic               in_range;
  logic signed [34:0] total;
  logic signed [31:0] cur_d;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;

  logic signed [31:0] mul_a, mul_b, mul_p;

  logic [AW-1:0]      clr_q;
  logic               done_q;

  // Latched command and working registers.
  logic               op_q;
  logic               inr_q;
  logic [AW-1:0]      addr_q;
  logic signed [31:0] cur_q;
  logic signed [31:0] alpha_q;
  logic signed [31:0] diff_q;
  logic signed [31:0] v_q;
  logic signed [31:0] prev_q;
  logic signed [31:0] slope_q;
  logic signed [31:0] f1_q;
  logic signed [31:0] filt_q;
  logic [15:0]        cnt_q;

  lnsf_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .index_i (cfg_index_i),
    .data_i  (cfg_data_i),
    .cfg_o   (cfg)
  );

  assign busy   = (state_q != lnsf_pkg::ST_IDLE);
  assign accept = start && !busy;

  // The index is widened so that tables both smaller and larger than the
  // index range compare and address correctly.
  assign idx_wide = {8'd0, neuron_index_i};
  assign in_range = (idx_wide < 16'(NEURONS));

  // The input current is summed exactly and saturated once.
  always_comb begin
    total = 35'(bias_current_i) + 35'(cfg.offset_current);
    if (lnsf_pkg::EXC_INPUTS >= 1) begin
      total = total + 35'(exc_current_0_i);
    end
    if (lnsf_pkg::EXC_INPUTS >= 2) begin
      total = total + 35'(exc_current_1_i);
    end
    if (lnsf_pkg::INH_INPUTS >= 1) begin
      total = total - 35'(inh_current_0_i);
    end
    if (lnsf_pkg::INH_INPUTS >= 2) begin
      total = total - 35'(inh_current_1_i);
    end
    if (total[34:31] == {4{total[31]}}) begin
      cur_d = total[31:0];
    end else begin
      cur_d = total[34] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
  end

  // The state memory is read at the edge that takes the command, so the
  // entry is ready in the first working cycle.
  lnsf_state_ram #(
    .Depth (NEURONS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wdata),
    .re_i    (accept),
    .raddr_i (idx_wide[AW-1:0]),
    .rdata_o (rd)
  );

  // Writes happen during the clearing pass and in the last working cycle.
  // Busy stays high through that cycle, so no read can meet a pending write.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_q;
    wdata     = '{voltage: v_q, prev_voltage: prev_q, slope: slope_q,
                  filtered: filt_q, refractory: cnt_q};
    if (state_q == lnsf_pkg::ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
      wdata     = '0;
    end else if (state_q == lnsf_pkg::ST_FINISH) begin
      ram_we = inr_q;
    end
  end

  // One shared multiplier; its operands follow the step of the sequence.
  always_comb begin
    mul_a = cur_q;
    mul_b = cfg.membrane_resistance;
    case (state_q)
      lnsf_pkg::ST_DECAY: begin
        mul_a = cfg.decay_factor;
        mul_b = diff_q;
      end
      lnsf_pkg::ST_SLOPE: begin
        mul_a = rd.filtered;
        mul_b = cfg.slope_gain;
      end
      lnsf_pkg::ST_FMUL: begin
        mul_a = slope_q;
        mul_b = cfg.slope_gain_complement;
      end
      default: ;
    endcase
  end

  lnsf_mul u_mul (
    .clk_i     (clk_i),
    .a_i       (mul_a),
    .b_i       (mul_b),
    .product_o (mul_p)
  );

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lnsf_pkg::ST_CLEAR;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == lnsf_pkg::ST_FINISH);
      if (state_q == lnsf_pkg::ST_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lnsf_pkg::ST_CLEAR: begin
        if (clr_q == AW'(NEURONS - 1)) begin
          state_d = lnsf_pkg::ST_IDLE;
        end
      end
      lnsf_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = lnsf_pkg::ST_START;
        end
      end
      lnsf_pkg::ST_START: begin
        if (!inr_q || (lnsf_pkg::op_e'(op_q) == lnsf_pkg::OP_SPIKED)) begin
          state_d = lnsf_pkg::ST_FINISH;
        end else if (rd.refractory != '0) begin
          state_d = lnsf_pkg::ST_SLOPE;
        end else begin
          state_d = lnsf_pkg::ST_ALPHA;
        end
      end
      lnsf_pkg::ST_ALPHA:  state_d = lnsf_pkg::ST_DIFF;
      lnsf_pkg::ST_DIFF:   state_d = lnsf_pkg::ST_DECAY;
      lnsf_pkg::ST_DECAY:  state_d = lnsf_pkg::ST_VOLT;
      lnsf_pkg::ST_VOLT:   state_d = lnsf_pkg::ST_SLOPE;
      lnsf_pkg::ST_SLOPE:  state_d = lnsf_pkg::ST_FMUL;
      lnsf_pkg::ST_FMUL:   state_d = lnsf_pkg::ST_FILT;
      lnsf_pkg::ST_FILT:   state_d = lnsf_pkg::ST_FINISH;
      lnsf_pkg::ST_FINISH: state_d = lnsf_pkg::ST_IDLE;
      default:             state_d = lnsf_pkg::ST_IDLE;
    endcase
  end

  // Datapath registers. The result fields are taken straight from v_q,
  // slope_q and filt_q, which hold through the result beat.
  always_ff @(posedge clk_i) begin
    case (state_q)
      lnsf_pkg::ST_IDLE: begin
        if (accept) begin
          op_q   <= operation_i;
          inr_q  <= in_range;
          addr_q <= idx_wide[AW-1:0];
          cur_q  <= cur_d;
        end
      end
      lnsf_pkg::ST_START: begin
        prev_q <= rd.prev_voltage;
        if (!inr_q) begin
          // An index outside the table reports zeros and changes nothing.
          v_q     <= '0;
          slope_q <= '0;
          filt_q  <= '0;
        end else if (lnsf_pkg::op_e'(op_q) == lnsf_pkg::OP_SPIKED) begin
          v_q     <= cfg.reset_voltage;
          cnt_q   <= cfg.refractory_steps;
          slope_q <= rd.slope;
          filt_q  <= rd.filtered;
        end else begin
          // Inside the refractory period the voltage holds and the timer
          // counts down; outside it the timer is already zero.
          v_q     <= rd.voltage;
          cnt_q   <= (rd.refractory == '0) ? '0 : rd.refractory - 16'd1;
          slope_q <= rd.slope;
          filt_q  <= rd.filtered;
        end
      end
      lnsf_pkg::ST_ALPHA: alpha_q <= lnsf_pkg::add_sat(mul_p, cfg.rest_voltage);
      lnsf_pkg::ST_DIFF:  diff_q  <= lnsf_pkg::sub_sat(alpha_q, rd.voltage);
      lnsf_pkg::ST_VOLT:  v_q     <= lnsf_pkg::sub_sat(alpha_q, mul_p);
      lnsf_pkg::ST_SLOPE: begin
        slope_q <= lnsf_pkg::sub_sat(v_q, rd.prev_voltage);
        prev_q  <= v_q;
      end
      lnsf_pkg::ST_FMUL: f1_q   <= mul_p;
      lnsf_pkg::ST_FILT: filt_q <= lnsf_pkg::add_sat(f1_q, mul_p);
      default: ;
    endcase
  end

  assign done_o             = done_q;
  assign membrane_voltage_o = v_q;
  assign voltage_slope_o    = slope_q;
  assign filtered_slope_o   = filt_q;

  // A result beat only follows the write-back cycle.
  `LNSF_ASSERT(a_done_after_finish,
               done_o |-> $past(state_q == lnsf_pkg::ST_FINISH),
               "result beat without write-back")
  // A taken command always starts the working sequence.
  `LNSF_ASSERT(a_start_follows_accept,
               accept |=> (state_q == lnsf_pkg::ST_START),
               "command taken but sequence not started")
  // An index outside the table reports zeros.
  `LNSF_ASSERT(a_out_of_range_zero,
               (done_o && !inr_q) |-> (membrane_voltage_o == '0 &&
                                       voltage_slope_o == '0 && filtered_slope_o == '0),
               "nonzero result for index outside table")
  // No result while the memory is still being cleared.
  `LNSF_ASSERT_NEVER(a_no_done_in_clear,
                     done_o && (state_q == lnsf_pkg::ST_CLEAR),
                     "result beat during clearing pass")

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the LIF neuron table with slope filter
// Sends update and spike commands through the start/busy port. It keeps a
// shadow copy of the neuron table and the parameter registers, and predicts
// the voltage, slope and filtered slope of every command. Each result beat is
// checked field by field against the oldest prediction. Register settings
// change between phases while no command is outstanding.
// ----------------------------------------------------------------------------
module tb;
  import lnsf_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int LIMIT_CYCLES = 400_000;
  localparam int TABLE_DEPTH  = 256;
  // The longest command is an update outside the refractory period; these
  // cycles after the last result settle the tail of the run.
  localparam int DRAIN_CYCLES = 12;
  // One in s16.15.
  localparam int FIX_ONE      = 32768;
  localparam int SPIKE_PCT    = 8;
  localparam int ITEMS_PER_SETTING = 106;

  typedef enum int {
    CFG_PLAUSIBLE,
    CFG_RANDOM,
    CFG_ALL_MAX,
    CFG_ALL_MIN,
    CFG_ZERO
  } cfg_kind_e;

  // One command beat as it was accepted.
  typedef struct {
    op_e                op;
    logic [7:0]         index;
    logic signed [31:0] exc0;
    logic signed [31:0] exc1;
    logic signed [31:0] inh0;
    logic signed [31:0] inh1;
    logic signed [31:0] bias;
  } neuron_cmd_t;

  // What the block must report for one command.
  typedef struct {
    logic [7:0]         index;
    logic signed [31:0] voltage;
    logic signed [31:0] slope;
    logic signed [31:0] filtered;
  } neuron_reading_t;

  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               start           = 1'b0;
  logic               busy;
  logic               operation_i     = 1'b0;
  logic [7:0]         neuron_index_i  = '0;
  logic signed [31:0] exc_current_0_i = '0;
  logic signed [31:0] exc_current_1_i = '0;
  logic signed [31:0] inh_current_0_i = '0;
  logic signed [31:0] inh_current_1_i = '0;
  logic signed [31:0] bias_current_i  = '0;
  logic               done_o;
  logic signed [31:0] membrane_voltage_o;
  logic signed [31:0] voltage_slope_o;
  logic signed [31:0] filtered_slope_o;
  logic               cfg_we_i        = 1'b0;
  logic [2:0]         cfg_index_i     = '0;
  logic [31:0]        cfg_data_i      = '0;

  // Shadow copy of the registers and of the neuron table, both zero after reset.
  cfg_t               model_cfg = '0;
  logic signed [31:0] nrn_voltage      [TABLE_DEPTH] = '{default: '0};
  logic signed [31:0] nrn_prev_voltage [TABLE_DEPTH] = '{default: '0};
  logic signed [31:0] nrn_slope        [TABLE_DEPTH] = '{default: '0};
  logic signed [31:0] nrn_filtered     [TABLE_DEPTH] = '{default: '0};
  logic        [15:0] nrn_refractory   [TABLE_DEPTH] = '{default: '0};

  // Predicted readings in command order; the block answers strictly in order.
  neuron_reading_t expected_readings[$];

  int sender_idle_pct = 0;
  int mismatch_count  = 0;
  int command_count   = 0;
  int spike_count     = 0;
  int reading_count   = 0;
  int setting_count   = 0;

  lif_neuron_with_slope_filter #(
    .NEURONS(TABLE_DEPTH)
  ) i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .operation_i       (operation_i),
    .neuron_index_i    (neuron_index_i),
    .exc_current_0_i   (exc_current_0_i),
    .exc_current_1_i   (exc_current_1_i),
    .inh_current_0_i   (inh_current_0_i),
    .inh_current_1_i   (inh_current_1_i),
    .bias_current_i    (bias_current_i),
    .done_o            (done_o),
    .membrane_voltage_o(membrane_voltage_o),
    .voltage_slope_o   (voltage_slope_o),
    .filtered_slope_o  (filtered_slope_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #(CLK_PERIOD / 2);
    clk_i = 1'b1;
    #(CLK_PERIOD / 2);
  end

  // --------------------------------------------------------------------------
  // Fixed-point arithmetic of the neuron, written at 64 bits.
  // --------------------------------------------------------------------------

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] sat_sum(input longint a, input longint b);
    return clamp32(a + b);
  endfunction

  // Full product, shifted down by the fraction width. The arithmetic shift
  // rounds toward minus infinity, which is what the block does for negative
  // products too.
  function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return clamp32(p >>> 15);
  endfunction

  // Applies one command to the shadow table and returns what the block has
  // to report for it.
  function automatic neuron_reading_t advance_neuron(input neuron_cmd_t cmd);
    longint             total;
    logic signed [31:0] drive;
    logic signed [31:0] alpha;
    logic signed [31:0] gap;
    logic signed [31:0] v;
    neuron_reading_t    r;
    if (cmd.op == OP_SPIKED) begin
      // A spike loads the reset voltage and rearms the timer; the slope and
      // its filtered value are reported as they stand.
      nrn_voltage[cmd.index]    = $signed(model_cfg.reset_voltage);
      nrn_refractory[cmd.index] = model_cfg.refractory_steps;
    end else begin
      if (nrn_refractory[cmd.index] == 16'd0) begin
        // The current is summed exactly and saturated only once at the end.
        total = longint'(cmd.exc0) + longint'(cmd.exc1)
              - longint'(cmd.inh0) - longint'(cmd.inh1)
              + longint'(cmd.bias) + longint'($signed(model_cfg.offset_current));
        drive = clamp32(total);
        alpha = sat_sum(longint'(fx_mul(drive, model_cfg.membrane_resistance)),
                        longint'($signed(model_cfg.rest_voltage)));
        gap   = sat_sum(longint'(alpha), -longint'(nrn_voltage[cmd.index]));
        v     = sat_sum(longint'(alpha),
                        -longint'(fx_mul(model_cfg.decay_factor, gap)));
        nrn_voltage[cmd.index] = v;
      end else begin
        // Inside the refractory period the voltage holds and the timer runs.
        nrn_refractory[cmd.index] = nrn_refractory[cmd.index] - 16'd1;
      end
      nrn_slope[cmd.index] = sat_sum(longint'(nrn_voltage[cmd.index]),
                                     -longint'(nrn_prev_voltage[cmd.index]));
      nrn_prev_voltage[cmd.index] = nrn_voltage[cmd.index];
      nrn_filtered[cmd.index] =
        sat_sum(longint'(fx_mul(nrn_filtered[cmd.index], model_cfg.slope_gain)),
                longint'(fx_mul(nrn_slope[cmd.index],
                                model_cfg.slope_gain_complement)));
    end
    r.index    = cmd.index;
    r.voltage  = nrn_voltage[cmd.index];
    r.slope    = nrn_slope[cmd.index];
    r.filtered = nrn_filtered[cmd.index];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Random values
  // --------------------------------------------------------------------------

  function automatic int span(input int lo, input int hi);
    return lo + int'($urandom_range(hi - lo, 0));
  endfunction

  // Mostly currents of a few nanoamperes, so that voltages move without
  // saturating; the rest are full-range values and the extremes.
  function automatic logic signed [31:0] pick_current();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return span(-4 * FIX_ONE, 4 * FIX_ONE);
    if (roll < 85) return $urandom;
    case ($urandom_range(0, 3))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  function automatic cfg_t make_cfg(input cfg_kind_e kind);
    cfg_t c;
    int   gain;
    c = '0;
    case (kind)
      CFG_PLAUSIBLE: begin
        // A resting cell near -65 mV with a decay between one half and one and a slope
        // filter whose two weights add up to one.
        gain                    = span(FIX_ONE / 2, FIX_ONE - 512);
        c.rest_voltage          = span(-70 * FIX_ONE, -60 * FIX_ONE);
        c.reset_voltage         = span(-75 * FIX_ONE, -65 * FIX_ONE);
        c.offset_current        = span(-2 * FIX_ONE, 2 * FIX_ONE);
        c.membrane_resistance   = span(FIX_ONE, 20 * FIX_ONE);
        c.decay_factor          = span(FIX_ONE / 2, FIX_ONE);
        c.refractory_steps      = 16'(span(0, 5));
        c.slope_gain            = gain;
        c.slope_gain_complement = FIX_ONE - gain;
      end
      CFG_RANDOM: begin
        c.rest_voltage          = $urandom;
        c.reset_voltage         = $urandom;
        c.offset_current        = $urandom;
        c.membrane_resistance   = $urandom;
        c.decay_factor          = $urandom;
        c.refractory_steps      = 16'(span(0, 12));
        c.slope_gain            = $urandom;
        c.slope_gain_complement = $urandom;
      end
      CFG_ALL_MAX: begin
        c.rest_voltage          = 32'sh7FFF_FFFF;
        c.reset_voltage         = 32'sh7FFF_FFFF;
        c.offset_current        = 32'sh7FFF_FFFF;
        c.membrane_resistance   = 32'sh7FFF_FFFF;
        c.decay_factor          = 32'sh7FFF_FFFF;
        c.refractory_steps      = 16'hFFFF;
        c.slope_gain            = 32'sh7FFF_FFFF;
        c.slope_gain_complement = 32'sh7FFF_FFFF;
      end
      CFG_ALL_MIN: begin
        c.rest_voltage          = 32'sh8000_0000;
        c.reset_voltage         = 32'sh8000_0000;
        c.offset_current        = 32'sh8000_0000;
        c.membrane_resistance   = 32'sh8000_0000;
        c.decay_factor          = 32'sh8000_0000;
        c.refractory_steps      = 16'h0000;
        c.slope_gain            = 32'sh8000_0000;
        c.slope_gain_complement = 32'sh8000_0000;
      end
      default: c = '0;
    endcase
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Register port
  // --------------------------------------------------------------------------

  // Called at a falling edge; the write lands at the next rising edge.
  task automatic write_register(input reg_idx_e idx, input logic [31:0] data);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    @(posedge clk_i);
    case (idx)
      REG_REST_VOLTAGE:   model_cfg.rest_voltage          = data;
      REG_RESET_VOLTAGE:  model_cfg.reset_voltage         = data;
      REG_OFFSET_CURRENT: model_cfg.offset_current        = data;
      REG_MEMBRANE_RES:   model_cfg.membrane_resistance   = data;
      REG_DECAY_FACTOR:   model_cfg.decay_factor          = data;
      // The timer register is 16 bits wide; the upper data bits are dropped.
      REG_REFRACT_STEPS:  model_cfg.refractory_steps      = data[15:0];
      REG_SLOPE_GAIN:     model_cfg.slope_gain            = data;
      default:            model_cfg.slope_gain_complement = data;
    endcase
    @(negedge clk_i);
  endtask

  task automatic apply_config(input cfg_t c);
    write_register(REG_REST_VOLTAGE,   c.rest_voltage);
    write_register(REG_RESET_VOLTAGE,  c.reset_voltage);
    write_register(REG_OFFSET_CURRENT, c.offset_current);
    write_register(REG_MEMBRANE_RES,   c.membrane_resistance);
    write_register(REG_DECAY_FACTOR,   c.decay_factor);
    // Random upper bits check that only the low half reaches the timer.
    write_register(REG_REFRACT_STEPS,  {16'($urandom), c.refractory_steps});
    write_register(REG_SLOPE_GAIN,     c.slope_gain);
    write_register(REG_SLOPE_GAIN_CMP, c.slope_gain_complement);
    cfg_we_i = 1'b0;
    setting_count++;
  endtask

  // --------------------------------------------------------------------------
  // Command port
  // --------------------------------------------------------------------------

  // Presents one command beat at a falling edge and holds it until a rising
  // edge sees busy low. Start stays high into the next call, so back-to-back
  // beats are never split by a low cycle unless the sender chooses to idle.
  task automatic send_command(input op_e op, input logic [7:0] index,
                              input logic signed [31:0] exc0,
                              input logic signed [31:0] exc1,
                              input logic signed [31:0] inh0,
                              input logic signed [31:0] inh1,
                              input logic signed [31:0] bias);
    neuron_cmd_t cmd;
    cmd = '{op, index, exc0, exc1, inh0, inh1, bias};
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start = 1'b0;
      @(negedge clk_i);
    end
    start           = 1'b1;
    operation_i     = op;
    neuron_index_i  = index;
    exc_current_0_i = exc0;
    exc_current_1_i = exc1;
    inh_current_0_i = inh0;
    inh_current_1_i = inh1;
    bias_current_i  = bias;
    do @(posedge clk_i); while (busy !== 1'b0);
    expected_readings.push_back(advance_neuron(cmd));
    command_count++;
    if (op == OP_SPIKED) spike_count++;
    @(negedge clk_i);
  endtask

  // Every command yields a result, so once nothing is outstanding the block
  // sits idle and may take register writes.
  task automatic drain_results();
    start = 1'b0;
    while (expected_readings.size() != 0) @(negedge clk_i);
  endtask

  // Most commands land on a group of eight neurons, so that state builds up
  // over many steps; the rest hit any neuron of the table.
  task automatic random_command(input int pool_base);
    op_e        op;
    logic [7:0] index;
    op    = ($urandom_range(0, 99) < SPIKE_PCT) ? OP_SPIKED : OP_UPDATE;
    index = ($urandom_range(0, 99) < 85) ? 8'(pool_base + $urandom_range(0, 7))
                                         : 8'($urandom);
    send_command(op, index, pick_current(), pick_current(), pick_current(),
                 pick_current(), pick_current());
  endtask

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------

  function automatic void check_field(input string name, input logic [7:0] index,
                                      input logic signed [31:0] want,
                                      input logic signed [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t ns: neuron %0d %s expected %0d (%h) actual %0d (%h)",
               $time, index, name, want, want, got, got);
    end
  endfunction

  // The result beat lasts one cycle and cannot be held off, so it is taken
  // at every rising edge where done_o is high.
  always @(posedge clk_i) begin : result_check
    neuron_reading_t want;
    if (rst_ni && done_o) begin
      reading_count++;
      if (expected_readings.size() == 0) begin
        mismatch_count++;
        $display("%0t ns: result beat expected none actual voltage %0d slope %0d",
                 $time, membrane_voltage_o, voltage_slope_o);
      end else begin
        want = expected_readings.pop_front();
        check_field("membrane_voltage", want.index, want.voltage, membrane_voltage_o);
        check_field("voltage_slope", want.index, want.slope, voltage_slope_o);
        check_field("filtered_slope", want.index, want.filtered, filtered_slope_o);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Register writes while the table is still being cleared, then the field
  // extremes, both operations, saturation of the current sum and of the
  // products, a refractory countdown, and a zero timer after a spike.
  task automatic test_directed_corners();
    cfg_t lab_cfg;
    lab_cfg = '0;
    lab_cfg.rest_voltage          = -65 * FIX_ONE;
    lab_cfg.reset_voltage         = -70 * FIX_ONE;
    lab_cfg.offset_current        = FIX_ONE;
    lab_cfg.membrane_resistance   = 10 * FIX_ONE;
    lab_cfg.decay_factor          = 29491;
    lab_cfg.refractory_steps      = 16'd2;
    lab_cfg.slope_gain            = 29491;
    lab_cfg.slope_gain_complement = FIX_ONE - 29491;
    sender_idle_pct = 0;
    apply_config(lab_cfg);

    send_command(OP_UPDATE, 8'd0, '0, '0, '0, '0, '0);
    // Current sum far above and then far below the 32-bit range.
    send_command(OP_UPDATE, 8'd255, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, '0, '0,
                 32'sh7FFF_FFFF);
    send_command(OP_UPDATE, 8'd255, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
                 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_command(OP_UPDATE, 8'd0, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                 32'sh8000_0000, 32'sh8000_0000);
    send_command(OP_UPDATE, 8'd1, '0, '0, '0, '0, 32'sh7FFF_FFFF);
    send_command(OP_UPDATE, 8'd1, '1, '1, '1, '1, '1);
    // A spike, two refractory steps, then integration resumes.
    send_command(OP_SPIKED, 8'd0, 32'sh1234_5678, '1, '0, 32'sh7FFF_FFFF, '1);
    repeat (3) send_command(OP_UPDATE, 8'd0, FIX_ONE, 2 * FIX_ONE, 0, FIX_ONE / 2, 0);
    send_command(OP_SPIKED, 8'd255, '0, '0, '0, '0, '0);
    repeat (3) send_command(OP_UPDATE, 8'd255, -FIX_ONE, 0, FIX_ONE, 0, 3 * FIX_ONE);

    // Every register at its largest value: products saturate, and the timer
    // is loaded with its full count.
    drain_results();
    apply_config(make_cfg(CFG_ALL_MAX));
    send_command(OP_UPDATE, 8'd2, FIX_ONE, 0, 0, 0, 0);
    send_command(OP_UPDATE, 8'd2, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0, 0);
    send_command(OP_SPIKED, 8'd2, 0, 0, 0, 0, 0);
    send_command(OP_UPDATE, 8'd2, FIX_ONE, 0, 0, 0, 0);

    // Every register at its most negative value; a spike leaves the timer at
    // zero, so the next update integrates at once.
    drain_results();
    apply_config(make_cfg(CFG_ALL_MIN));
    send_command(OP_UPDATE, 8'd3, FIX_ONE, 0, 0, 0, 0);
    send_command(OP_SPIKED, 8'd3, 0, 0, 0, 0, 0);
    send_command(OP_UPDATE, 8'd3, -FIX_ONE, FIX_ONE, 0, 0, 0);
    send_command(OP_UPDATE, 8'd3, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
                 32'sh7FFF_FFFF, 32'sh8000_0000);
  endtask

  // Well-formed spike trains: each neuron of a group spikes, sits out its
  // refractory period and comes back into integration.
  task automatic test_refractory_cycles();
    sender_idle_pct = 10;
    for (int round = 0; round < 6; round++) begin
      drain_results();
      apply_config(make_cfg(CFG_PLAUSIBLE));
      for (int n = 0; n < 8; n++) begin
        send_command(OP_SPIKED, 8'(n), pick_current(), pick_current(),
                     pick_current(), pick_current(), pick_current());
        repeat (int'(model_cfg.refractory_steps) + 2) begin
          send_command(OP_UPDATE, 8'(n), span(-FIX_ONE, 3 * FIX_ONE),
                       span(-FIX_ONE, 3 * FIX_ONE), span(0, FIX_ONE),
                       span(0, FIX_ONE), span(-FIX_ONE, FIX_ONE));
        end
      end
    end
  endtask

  // Random traffic through each kind of register setting. The extreme
  // settings aim their group at neurons 248 to 255, since a full timer would otherwise
  // freeze the group that the plausible settings use.
  task automatic test_random_traffic(input int idle_pct);
    cfg_kind_e kind;
    int        pool_base;
    sender_idle_pct = idle_pct;
    for (int k = CFG_PLAUSIBLE; k <= CFG_ZERO; k++) begin
      kind      = cfg_kind_e'(k);
      pool_base = (kind == CFG_ALL_MAX || kind == CFG_ALL_MIN) ? 248 : 0;
      drain_results();
      apply_config(make_cfg(kind));
      repeat (ITEMS_PER_SETTING) random_command(pool_base);
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_corners();
    test_refractory_cycles();
    // The sender idles lightly, then heavily, then not at all.
    test_random_traffic(10);
    test_random_traffic(86);
    test_random_traffic(0);

    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    $display("Run covered %0d commands, %0d of them spikes, under %0d register settings.",
             command_count, spike_count, setting_count);
    $display("%0d result beats were compared field by field; %0d fields differed.",
             reading_count, mismatch_count);
    if (mismatch_count == 0 && expected_readings.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Ends a run that hangs, for example when busy never falls.
  initial begin
    #(longint'(LIMIT_CYCLES) * CLK_PERIOD);
    $display("Run stopped by the time limit with %0d results outstanding.",
             expected_readings.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
